// ===== hw/rtl/two_view_point_triangulation_top_macros.svh =====
// Assertion macros for the two-view triangulation block.
// Used by two_view_point_triangulation_top; no other dependencies.
`ifndef TWO_VIEW_POINT_TRIANGULATION_TOP_MACROS_SVH
`define TWO_VIEW_POINT_TRIANGULATION_TOP_MACROS_SVH

// same-cycle implication
`define TVT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TVT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/tvt_pkg.sv =====
// Shared widths, codes, result type and operand selection tables for the
// triangulation pipeline. No dependencies.
package tvt_pkg;

  localparam int COEF_W  = 32;
  localparam int PIX_W   = 16;
  localparam int IDX_W   = 5;
  localparam int COEF_N  = 24;
  localparam int AB_W    = 49;   // A and B entries
  localparam int N_W     = 100;  // normal-equation entries
  localparam int C_W     = 201;  // cofactors
  localparam int D_W     = 304;  // determinants
  localparam int OUT_W   = 48;
  localparam int FRAC_SH = 17;   // 16 fraction bits plus one for rounding

  localparam int DIV_LAT = OUT_W + 3;

  // input word actions
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_POINT = 1'b1;

  typedef struct packed {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] z;
    logic                    sing;
  } res_t;

  // cycles through tvt_mul for an aw x bw product
  function automatic int mul_lat(int aw, int bw);
    return ((aw + 31) / 32) * ((bw + 31) / 32) + 2;
  endfunction

  // normal-equation products: 00 01 02 11 12 22, then rhs 0..2
  function automatic int nsel_i(int p);
    case (p)
      0, 1, 2: return 0;
      3, 4:    return 1;
      5:       return 2;
      6:       return 0;
      7:       return 1;
      default: return 2;
    endcase
  endfunction

  function automatic int nsel_j(int p);
    case (p)
      0:       return 0;
      1, 3:    return 1;
      default: return 2;
    endcase
  endfunction

  // cofactor product operands, as indexes into the normal-equation words
  function automatic int cf_a(int q);
    case (q)
      0: return 3;   1: return 4;   2: return 2;   3: return 1;
      4: return 1;   5: return 3;   6: return 0;   7: return 2;
      8: return 1;   9: return 0;   10: return 0;  default: return 1;
    endcase
  endfunction

  function automatic int cf_b(int q);
    case (q)
      0: return 5;   1: return 4;   2: return 4;   3: return 5;
      4: return 4;   5: return 2;   6: return 5;   7: return 2;
      8: return 2;   9: return 4;   10: return 3;  default: return 1;
    endcase
  endfunction

  // cofactor used by each determinant term (C00 C01 C02 C11 C12 C22)
  function automatic int dt_cf(int q);
    case (q)
      0, 3:     return 0;
      1, 4, 6:  return 1;
      2, 5, 9:  return 2;
      7:        return 3;
      8, 10:    return 4;
      default:  return 5;
    endcase
  endfunction

endpackage

// ===== hw/rtl/tvt_mul.sv =====
// Pipelined signed multiplier: sign-magnitude, one 32x32 partial product per stage.
// Standalone.
module tvt_mul #(
  parameter int AW = 49,
  parameter int BW = 49
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [AW-1:0]    a_i,
  input  logic signed [BW-1:0]    b_i,
  output logic signed [AW+BW-1:0] p_o
);
  localparam int NA  = (AW + 31) / 32;
  localparam int NB  = (BW + 31) / 32;
  localparam int NS  = NA * NB;
  localparam int PW  = AW + BW;
  localparam int APW = NA * 32;
  localparam int BPW = NB * 32;

  logic [APW-1:0] ma_q  [NS];
  logic [BPW-1:0] mb_q  [NS];
  logic           sg_q  [NS+1];
  logic [PW-1:0]  acc_q [NS+1];
  logic signed [PW-1:0] p_q;
  logic [AW-1:0]  ma_d;
  logic [BW-1:0]  mb_d;

  // magnitudes
  assign ma_d = a_i[AW-1] ? AW'(-a_i) : AW'(a_i);
  assign mb_d = b_i[BW-1] ? BW'(-b_i) : BW'(b_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ma_q[0]  <= APW'(ma_d);
      mb_q[0]  <= BPW'(mb_d);
      sg_q[0]  <= a_i[AW-1] ^ b_i[BW-1];
      acc_q[0] <= '0;
    end
  end

  // one 32x32 partial product per stage, slices of a run fastest
  for (genvar k = 1; k <= NS; k++) begin : g_stage
    localparam int IA = (k - 1) % NA;
    localparam int IB = (k - 1) / NA;
    logic [63:0] pp;
    assign pp = ma_q[k-1][32*IA +: 32] * mb_q[k-1][32*IB +: 32];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        acc_q[k] <= acc_q[k-1] + (PW'(pp) << (32 * (IA + IB)));
        sg_q[k]  <= sg_q[k-1];
      end
    end
    if (k < NS) begin : g_pass
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          ma_q[k] <= ma_q[k-1];
          mb_q[k] <= mb_q[k-1];
        end
      end
    end
  end

  // restore sign
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= sg_q[NS] ? -$signed(acc_q[NS]) : $signed(acc_q[NS]);
    end
  end

  assign p_o = p_q;
endmodule

// ===== hw/rtl/tvt_dly.sv =====
// Enabled delay line with cleared stages, for valid bits and side data.
// Standalone.
module tvt_dly #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);
  logic [W-1:0] r_q [DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) r_q[i] <= '0;
    end else if (en_i) begin
      r_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) r_q[i] <= r_q[i-1];
    end
  end

  assign q_o = r_q[DEPTH-1];
endmodule

// ===== hw/rtl/tvt_div.sv =====
// Pipelined rounded quotient round(num*2^16/den), saturated to 48 bits.
// Uses tvt_pkg; one quotient bit per stage.
module tvt_div #(
  parameter int DW = 304
) (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic signed [DW-1:0]           num_i,
  input  logic signed [DW-1:0]           den_i,
  output logic signed [tvt_pkg::OUT_W-1:0] q_o
);
  import tvt_pkg::*;

  localparam int QB = OUT_W + 1;
  localparam int RW = DW + 50;

  logic [RW-1:0] r_q  [QB];
  logic [RW-1:0] d_q  [QB];
  logic [QB-1:0] q_q  [QB+1];
  logic          ng_q [QB+1];
  logic [DW-1:0] mn, md;
  logic signed [OUT_W-1:0] res_q;
  logic [OUT_W-1:0] mag;
  logic          sat;

  assign mn = num_i[DW-1] ? DW'(-num_i) : DW'(num_i);
  assign md = den_i[DW-1] ? DW'(-den_i) : DW'(den_i);

  // setup: numerator scaled and biased by half the doubled divisor
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]  <= (RW'(mn) << FRAC_SH) + RW'(md);
      d_q[0]  <= RW'(md) << 1;
      q_q[0]  <= '0;
      ng_q[0] <= num_i[DW-1] ^ den_i[DW-1];
    end
  end

  // restoring steps, top quotient bit flags overflow
  for (genvar j = 1; j <= QB; j++) begin : g_bit
    localparam int B = QB - j;
    logic [RW-1:0] dsh;
    logic          ge;
    assign dsh = d_q[j-1] << B;
    assign ge  = r_q[j-1] >= dsh;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        q_q[j]  <= {q_q[j-1][QB-2:0], ge};
        ng_q[j] <= ng_q[j-1];
      end
    end
    if (j < QB) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          r_q[j] <= ge ? r_q[j-1] - dsh : r_q[j-1];
          d_q[j] <= d_q[j-1];
        end
      end
    end
  end

  // saturate and apply sign
  always_comb begin
    if (ng_q[QB]) begin
      sat = q_q[QB] > QB'({1'b1, {(OUT_W-1){1'b0}}});
      mag = sat ? {1'b1, {(OUT_W-1){1'b0}}} : q_q[QB][OUT_W-1:0];
    end else begin
      sat = q_q[QB][QB-1] | q_q[QB][QB-2];
      mag = sat ? {1'b0, {(OUT_W-1){1'b1}}} : q_q[QB][OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= ng_q[QB] ? -$signed(mag) : $signed(mag);
    end
  end

  assign q_o = res_q;
endmodule

// ===== hw/rtl/two_view_point_triangulation_top.sv =====
// Two-view point triangulation: normal equations plus Cramer's rule.
// Throughput: one word per cycle while in_stall_o is low; loads write the store at acceptance.
// Three multiplier levels (one 32x32 product per stage) and the divider set the depth.
// Reset clears all valid bits; the coefficient store is not cleared.
// Uses tvt_pkg, tvt_mul, tvt_dly, tvt_div and the assertion macros.
`include "two_view_point_triangulation_top_macros.svh"

module two_view_point_triangulation_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 action_i,
  input  logic [tvt_pkg::IDX_W-1:0]            coef_index_i,
  input  logic signed [tvt_pkg::COEF_W-1:0]    coef_value_i,
  input  logic [tvt_pkg::PIX_W-1:0]            first_u_i,
  input  logic [tvt_pkg::PIX_W-1:0]            first_v_i,
  input  logic [tvt_pkg::PIX_W-1:0]            second_u_i,
  input  logic [tvt_pkg::PIX_W-1:0]            second_v_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [tvt_pkg::OUT_W-1:0]     point_x_o,
  output logic signed [tvt_pkg::OUT_W-1:0]     point_y_o,
  output logic signed [tvt_pkg::OUT_W-1:0]     point_z_o,
  output logic                                 singular_o
);
  import tvt_pkg::*;

  localparam int MUL1_LAT = mul_lat(AB_W, AB_W);
  localparam int MUL2_LAT = mul_lat(N_W, N_W);
  localparam int MUL3_LAT = mul_lat(C_W, N_W);
  localparam int CF_LAT   = MUL2_LAT + 1;
  localparam int TOT_LAT  = MUL1_LAT + 1 + CF_LAT + MUL3_LAT + 1 + DIV_LAT;

  logic en, in_acc;
  logic [COEF_W-1:0] store_q [COEF_N];
  logic [PIX_W-1:0]  pix [4];
  logic signed [AB_W-1:0] a_d [4][3];
  logic signed [AB_W-1:0] b_d [4];
  logic signed [AB_W-1:0] a_q [4][3];
  logic signed [AB_W-1:0] b_q [4];
  logic va_q;
  logic signed [2*AB_W-1:0] mp [4][9];
  logic signed [N_W-1:0]    s_q [9];
  logic signed [2*N_W-1:0]  cp [12];
  logic signed [C_W-1:0]    c_q [6];
  logic [N_W-1:0]           sd [6];
  logic signed [C_W+N_W-1:0] dp [12];
  logic signed [D_W-1:0]    d_q [4];
  logic signed [OUT_W-1:0]  qv [3];
  logic lv, lsing;
  res_t lres, out_q, skid_q;
  logic out_vq, skid_vq;

  // pipeline advances unless the skid stage is holding a word
  assign en         = !skid_vq;
  assign in_stall_o = skid_vq;
  assign in_acc     = in_valid_i && !in_stall_o;

  // coefficient store
  always_ff @(posedge clk_i) begin
    if (in_acc && (action_i == ACT_LOAD) && (coef_index_i < IDX_W'(COEF_N))) begin
      store_q[coef_index_i] <= coef_value_i;
    end
  end

  assign pix[0] = first_u_i;
  assign pix[1] = first_v_i;
  assign pix[2] = second_u_i;
  assign pix[3] = second_v_i;

  // rows of A and B: camera k>>1, image row k&1
  always_comb begin
    int base, row;
    base = 0;
    row  = 0;
    for (int k = 0; k < 4; k++) begin
      base = (k >> 1) * 12;
      row  = k & 1;
      for (int j = 0; j < 3; j++) begin
        a_d[k][j] = $signed({1'b0, pix[k]}) * $signed(store_q[base+8+j])
                    - ($signed(store_q[base+row*4+j]) <<< 4);
      end
      b_d[k] = ($signed(store_q[base+row*4+3]) <<< 4)
               - $signed({1'b0, pix[k]}) * $signed(store_q[base+11]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q <= a_d;
      b_q <= b_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en) begin
      va_q <= in_acc && (action_i == ACT_POINT);
    end
  end

  // A^T A and A^T B products
  for (genvar k = 0; k < 4; k++) begin : g_row
    for (genvar p = 0; p < 9; p++) begin : g_np
      if (p < 6) begin : g_aa
        tvt_mul #(.AW(AB_W), .BW(AB_W)) u_mul (
          .clk_i (clk_i), .en_i (en),
          .a_i (a_q[k][nsel_i(p)]), .b_i (a_q[k][nsel_j(p)]), .p_o (mp[k][p])
        );
      end else begin : g_ab
        tvt_mul #(.AW(AB_W), .BW(AB_W)) u_mul (
          .clk_i (clk_i), .en_i (en),
          .a_i (a_q[k][nsel_i(p)]), .b_i (b_q[k]), .p_o (mp[k][p])
        );
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int p = 0; p < 9; p++) begin
        s_q[p] <= N_W'(mp[0][p]) + N_W'(mp[1][p]) + N_W'(mp[2][p]) + N_W'(mp[3][p]);
      end
    end
  end

  // cofactors of the symmetric normal matrix
  for (genvar q = 0; q < 12; q++) begin : g_cf
    tvt_mul #(.AW(N_W), .BW(N_W)) u_mul (
      .clk_i (clk_i), .en_i (en),
      .a_i (s_q[cf_a(q)]), .b_i (s_q[cf_b(q)]), .p_o (cp[q])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int m = 0; m < 6; m++) begin
        c_q[m] <= C_W'(cp[2*m]) - C_W'(cp[2*m+1]);
      end
    end
  end

  // first row and rhs wait for the cofactors
  for (genvar t = 0; t < 6; t++) begin : g_sd
    localparam int SI = (t < 3) ? t : t + 3;
    tvt_dly #(.W(N_W), .DEPTH(CF_LAT)) u_dly (
      .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en),
      .d_i (s_q[SI]), .q_o (sd[t])
    );
  end

  // determinant and the three Cramer numerators
  for (genvar q = 0; q < 12; q++) begin : g_dt
    localparam int G  = q / 3;
    localparam int T  = q % 3;
    localparam int LI = (G == 0) ? T : T + 3;
    tvt_mul #(.AW(C_W), .BW(N_W)) u_mul (
      .clk_i (clk_i), .en_i (en),
      .a_i (c_q[dt_cf(q)]), .b_i ($signed(sd[LI])), .p_o (dp[q])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int g = 0; g < 4; g++) begin
        d_q[g] <= D_W'(dp[3*g]) + D_W'(dp[3*g+1]) + D_W'(dp[3*g+2]);
      end
    end
  end

  // quotients
  for (genvar g = 0; g < 3; g++) begin : g_div
    tvt_div #(.DW(D_W)) u_div (
      .clk_i (clk_i), .en_i (en),
      .num_i (d_q[g+1]), .den_i (d_q[0]), .q_o (qv[g])
    );
  end

  tvt_dly #(.W(1), .DEPTH(DIV_LAT)) u_sing_dly (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en),
    .d_i (d_q[0] == '0), .q_o (lsing)
  );

  tvt_dly #(.W(1), .DEPTH(TOT_LAT)) u_valid_dly (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en),
    .d_i (va_q), .q_o (lv)
  );

  always_comb begin
    lres.sing = lsing;
    lres.x    = lsing ? '0 : qv[0];
    lres.y    = lsing ? '0 : qv[1];
    lres.z    = lsing ? '0 : qv[2];
  end

  // output register with skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vq  <= 1'b0;
      skid_vq <= 1'b0;
    end else if (!out_vq || !out_stall_i) begin
      if (skid_vq) begin
        out_vq  <= 1'b1;
        skid_vq <= 1'b0;
      end else begin
        out_vq <= lv;
      end
    end else if (!skid_vq && lv) begin
      skid_vq <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vq || !out_stall_i) begin
      out_q <= skid_vq ? skid_q : lres;
    end else if (!skid_vq && lv) begin
      skid_q <= lres;
    end
  end

  assign out_valid_o = out_vq;
  assign point_x_o   = out_q.x;
  assign point_y_o   = out_q.y;
  assign point_z_o   = out_q.z;
  assign singular_o  = out_q.sing;

  // checks
  `TVT_ASSERT_IMP(a_skid_out, clk_i, rst_ni, skid_vq, out_vq, "skid word without output word")
  `TVT_ASSERT_IMP(a_skid_rise, clk_i, rst_ni, $rose(skid_vq), $past(out_vq && out_stall_i), "skid filled without a stalled output")
  `TVT_ASSERT_IMP(a_sing_zero, clk_i, rst_ni, out_vq && out_q.sing, (out_q.x == '0) && (out_q.y == '0) && (out_q.z == '0), "singular word carries a nonzero point")
  `TVT_ASSERT_NXT(a_skid_hold, clk_i, rst_ni, skid_vq && out_stall_i, skid_vq, "skid word dropped while output stalled")

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for two_view_point_triangulation_top.
// Holds its own exact-arithmetic solver for the expected points; needs tvt_pkg and the RTL.
// Stimulus: camera loads, directed and random point words, varied idling and back-pressure.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tvt_pkg::*;

  typedef logic signed [399:0] wide_t;
  typedef wide_t mat_t [3][3];

  localparam int   STALL_LIMIT = 3000;
  localparam int   DRAIN_CYCLES = 90;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic action_i = ACT_LOAD;
  logic [IDX_W-1:0] coef_index_i = '0;
  logic signed [COEF_W-1:0] coef_value_i = '0;
  logic [PIX_W-1:0] first_u_i = '0, first_v_i = '0, second_u_i = '0, second_v_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [OUT_W-1:0] point_x_o, point_y_o, point_z_o;
  logic singular_o;

  // camera coefficients as the block should hold them
  logic signed [31:0] cam_coef [24];
  res_t pending_points [$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_rx = 1'b0;
  int points_checked = 0;
  int loads_sent = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  two_view_point_triangulation_top DUT (.*);

  always #5 clk_i = ~clk_i;

  // ---- solver ----
  function automatic wide_t det3(mat_t m);
    wide_t t0, t1, t2;
    t0 = m[1][1] * m[2][2] - m[1][2] * m[2][1];
    t1 = m[1][0] * m[2][2] - m[1][2] * m[2][0];
    t2 = m[1][0] * m[2][1] - m[1][1] * m[2][0];
    return m[0][0] * t0 - m[0][1] * t1 + m[0][2] * t2;
  endfunction

  // round(num * 2^16 / den), ties away from zero, saturated to 48 bits
  function automatic logic signed [OUT_W-1:0] round_quot(wide_t num, wide_t den);
    logic [399:0] mn, md, q;
    bit neg;
    mn = num < 0 ? -num : num;
    md = den < 0 ? -den : den;
    neg = (num < 0) != (den < 0);
    q = ((mn << 17) + md) / (md << 1);
    if (neg) begin
      if (q > 400'h8000_0000_0000) q = 400'h8000_0000_0000;
      return -q[OUT_W-1:0];
    end
    if (q > 400'h7FFF_FFFF_FFFF) q = 400'h7FFF_FFFF_FFFF;
    return q[OUT_W-1:0];
  endfunction

  function automatic res_t solve_point(logic [15:0] u1, logic [15:0] v1,
                                       logic [15:0] u2, logic [15:0] v2);
    longint pix [4], a [4][3], b [4];
    mat_t n, m;
    wide_t rhs [3], det;
    res_t r;
    int base, row;
    pix[0] = u1; pix[1] = v1; pix[2] = u2; pix[3] = v2;
    for (int k = 0; k < 4; k++) begin
      base = (k / 2) * 12;
      row = k % 2;
      for (int j = 0; j < 3; j++)
        a[k][j] = pix[k] * longint'(cam_coef[base + 8 + j])
                - longint'(cam_coef[base + row * 4 + j]) * 16;
      b[k] = longint'(cam_coef[base + row * 4 + 3]) * 16 - pix[k] * longint'(cam_coef[base + 11]);
    end
    for (int i = 0; i < 3; i++) begin
      rhs[i] = 0;
      for (int k = 0; k < 4; k++) rhs[i] += wide_t'(a[k][i]) * wide_t'(b[k]);
      for (int j = 0; j < 3; j++) begin
        n[i][j] = 0;
        for (int k = 0; k < 4; k++) n[i][j] += wide_t'(a[k][i]) * wide_t'(a[k][j]);
      end
    end
    det = det3(n);
    r = '0;
    if (det == 0) begin
      r.sing = 1'b1;
      return r;
    end
    m = n; for (int i = 0; i < 3; i++) m[i][0] = rhs[i];
    r.x = round_quot(det3(m), det);
    m = n; for (int i = 0; i < 3; i++) m[i][1] = rhs[i];
    r.y = round_quot(det3(m), det);
    m = n; for (int i = 0; i < 3; i++) m[i][2] = rhs[i];
    r.z = round_quot(det3(m), det);
    return r;
  endfunction

  // ---- sending side ----
  task automatic send_word(logic act, logic [IDX_W-1:0] idx, logic signed [31:0] val,
                           logic [15:0] u1, logic [15:0] v1,
                           logic [15:0] u2, logic [15:0] v2);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    coef_index_i <= idx;
    coef_value_i <= val;
    first_u_i <= u1; first_v_i <= v1; second_u_i <= u2; second_v_i <= v2;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    // word accepted at this edge
    if (act == ACT_POINT) pending_points = {pending_points, solve_point(u1, v1, u2, v2)};
    else begin
      loads_sent++;
      if (idx < COEF_N) cam_coef[idx] = val;
    end
  endtask

  function automatic logic [PIX_W-1:0] rand_pix();
    return PIX_W'($urandom);
  endfunction

  task automatic load_coef(int idx, logic signed [31:0] val);
    send_word(ACT_LOAD, idx[IDX_W-1:0], val, rand_pix(), rand_pix(), rand_pix(), rand_pix());
  endtask

  task automatic send_point(logic [15:0] u1, logic [15:0] v1,
                            logic [15:0] u2, logic [15:0] v2);
    send_word(ACT_POINT, IDX_W'($urandom), $urandom, u1, v1, u2, v2);
  endtask

  function automatic logic signed [31:0] rand_coef();
    case ($urandom_range(2))
      0: return $urandom;
      1: return $signed($urandom_range(2 * 1048576)) - 1048576;
      default: return $signed($urandom_range(4 * 65536)) - 2 * 65536;
    endcase
  endfunction

  // first camera [I|0], second [I|t], both Q16.16
  task automatic load_simple_rig();
    for (int i = 0; i < COEF_N; i++)
      load_coef(i, (i % 12) / 4 == (i % 4) ? 32'sd65536 : 32'sd0);
    load_coef(15, -32'sd131072);
  endtask

  // ---- tests ----
  task automatic test_directed_points();
    load_simple_rig();
    send_point(16'd0, 16'd0, 16'd0, 16'd0);
    send_point(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_point(16'h0010, 16'h0020, 16'h0008, 16'h0020);
    send_point(16'h8000, 16'h7FFF, 16'h0001, 16'hFFFE);
    // extreme coefficients: saturation of the result is likely
    load_coef(0, 32'sh8000_0000);
    load_coef(5, 32'sh7FFF_FFFF);
    load_coef(23, 32'sd1);
    send_point(16'h1234, 16'hFFFF, 16'h0000, 16'h4321);
    send_point(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
  endtask

  task automatic test_ignored_index();
    for (int i = COEF_N; i < 32; i++) load_coef(i, $urandom);
    send_point(rand_pix(), rand_pix(), rand_pix(), rand_pix());
  endtask

  task automatic test_singular();
    for (int i = 0; i < COEF_N; i++) load_coef(i, 32'sd0);
    send_point(16'h0100, 16'h0200, 16'h0300, 16'h0400);
    load_simple_rig();
  endtask

  task automatic test_backpressure();
    hold_rx = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk_i);
        hold_rx = 1'b0;
      end
      for (int k = 0; k < 150; k++) send_point(rand_pix(), rand_pix(), rand_pix(), rand_pix());
    join
  endtask

  task automatic test_random(int words);
    int n = 0;
    while (n < words) begin
      if ($urandom_range(9) == 0) begin
        // full reload of both cameras
        for (int i = 0; i < COEF_N; i++) load_coef(i, rand_coef());
        n += COEF_N;
      end else if ($urandom_range(9) < 3) begin
        load_coef($urandom_range(31), rand_coef());
        n++;
      end else begin
        send_point(rand_pix(), rand_pix(), rand_pix(), rand_pix());
        n++;
      end
    end
  endtask

  // ---- receiving side ----
  always @(posedge clk_i) out_stall_i <= hold_rx || ($urandom_range(99) < recv_stall_pct);

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_points.size() == 0) begin
        $display("%t: result word with nothing expected", $realtime);
        mismatches++;
      end else begin
        want = pending_points.pop_front();
        points_checked++;
        if (point_x_o !== want.x) begin
          $display("%t: point_x expected %0d actual %0d", $realtime, want.x, point_x_o);
          mismatches++;
        end
        if (point_y_o !== want.y) begin
          $display("%t: point_y expected %0d actual %0d", $realtime, want.y, point_y_o);
          mismatches++;
        end
        if (point_z_o !== want.z) begin
          $display("%t: point_z expected %0d actual %0d", $realtime, want.z, point_z_o);
          mismatches++;
        end
        if (singular_o !== want.sing) begin
          $display("%t: singular expected %0b actual %0b", $realtime, want.sing, singular_o);
          mismatches++;
        end
      end
    end
  end

  // watchdog: cycles without any word moving
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 37;
    recv_stall_pct = 58;
    test_directed_points();
    test_ignored_index();
    test_singular();
    test_random(85);
    send_idle_pct = 58;
    recv_stall_pct = 37;
    test_random(85);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_backpressure();
    test_random(85);
    in_valid_i <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Covered %0d coefficient loads and %0d checked points, incl. singular,",
             loads_sent, points_checked);
    $display("saturating, ignored-index and back-pressure cases.");
    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
